### design/ppmt_pkg.sv
package ppmt_pkg;

    localparam int PAGES_DEF      = 16;
    localparam int PAGE_WORDS_DEF = 64;

    localparam int ID_W     = 32;
    localparam int OFF_W    = 7;
    localparam int WORD_W   = 32;
    localparam int BUCKET_W = 4;

    localparam int CMD_LSB   = 0;
    localparam int ID_LSB    = 3;
    localparam int OFF_LSB   = 35;
    localparam int WDATA_LSB = 42;
    localparam int S_DATA_W  = 80;

    localparam int OK_LSB     = 0;
    localparam int BUCKET_LSB = 1;
    localparam int RDATA_LSB  = 5;
    localparam int M_DATA_W   = 40;

    typedef enum logic [2:0] {
        CMD_ALLOC  = 3'd0,
        CMD_SEARCH = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_ENCODE,
        ST_EXEC,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        logic take;
        logic compare;
        logic encode;
        logic execute;
        logic publish;
    } ctl_cmd_t;

    typedef struct packed {
        logic rem_busy;
        logic out_free;
    } ctl_stat_t;

endpackage

### design/ppmt_rem.sv
module ppmt_rem #(
    parameter int DIVISOR = ppmt_pkg::PAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ppmt_pkg::ID_W-1:0]     dividend,
    output logic                          busy,
    output logic [ppmt_pkg::BUCKET_W-1:0] bucket
);
    import ppmt_pkg::*;

    localparam int  DW      = $clog2(DIVISOR);
    localparam bit  IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;

    logic [DW-1:0] rem_reg;

    assign bucket = BUCKET_W'(rem_reg);

    generate
        if (IS_POW2) begin : g_mask
            always_ff @(posedge aclk) begin
                if (start) begin
                    rem_reg <= dividend[DW-1:0];
                end
            end
            assign busy = 1'b0;
        end else begin : g_recip
            // quotient by reciprocal multiply, remainder from the low bits next cycle
            localparam int            SH    = ID_W + DW;
            localparam logic [ID_W:0] RECIP =
                (ID_W+1)'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

            logic [2*ID_W:0] prod;
            logic [DW-1:0]   quot_lo_reg;
            logic [DW-1:0]   x_lo_reg;
            logic            stage_reg;

            assign prod = (2*ID_W+1)'(dividend) * (2*ID_W+1)'(RECIP);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stage_reg <= 1'b0;
                end else begin
                    stage_reg <= start;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    quot_lo_reg <= DW'(prod >> SH);
                    x_lo_reg    <= dividend[DW-1:0];
                end
                if (stage_reg) begin
                    rem_reg <= x_lo_reg - DW'(quot_lo_reg * DW'(DIVISOR));
                end
            end

            assign busy = stage_reg;
        end
    endgenerate

endmodule

### design/ppmt_ctrl.sv
module ppmt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  ppmt_pkg::ctl_stat_t  stat,
    output ppmt_pkg::ctl_cmd_t   cmd
);
    import ppmt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:  state_next = ST_ENCODE;
            ST_ENCODE: state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_RESPOND;
            ST_RESPOND: begin
                if (!stat.rem_busy && stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:    cmd.take    = 1'b1;
            ST_MATCH:   cmd.compare = 1'b1;
            ST_ENCODE:  cmd.encode  = 1'b1;
            ST_EXEC:    cmd.execute = 1'b1;
            ST_RESPOND: cmd.publish = !stat.rem_busy && stat.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

### design/ppmt_dp.sv
module ppmt_dp #(
    parameter int PAGES      = ppmt_pkg::PAGES_DEF,
    parameter int PAGE_WORDS = ppmt_pkg::PAGE_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ppmt_pkg::ctl_cmd_t            cmd,
    output ppmt_pkg::ctl_stat_t           stat,
    input  logic                          s_tvalid,
    input  logic [ppmt_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ppmt_pkg::M_DATA_W-1:0] m_tdata
);
    import ppmt_pkg::*;

    localparam int PW    = $clog2(PAGES);
    localparam int DEPTH = PAGES * PAGE_WORDS;
    localparam int AW    = $clog2(DEPTH);

    // request
    cmd_t               cmd_reg;
    logic [ID_W-1:0]    id_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [WORD_W-1:0]  wdata_reg;

    // page table
    logic [PAGES-1:0]   in_use_reg;
    logic [ID_W-1:0]    owner_reg [PAGES];

    logic [PAGES-1:0]   match_reg;
    logic [PAGES-1:0]   free_reg;

    logic               found_reg;
    logic               full_reg;
    logic [PW-1:0]      page_reg;
    logic [PW-1:0]      free_page_reg;
    logic               found_next;
    logic               full_next;
    logic [PW-1:0]      page_next;
    logic [PW-1:0]      free_page_next;

    logic               ok_reg;
    logic               rd_sel_reg;
    logic               ok_next;
    logic               alloc_en;
    logic               del_en;
    logic               wr_en;
    logic               rd_en;
    logic               off_ok;
    logic               rem_start;
    logic               rem_busy;
    logic [BUCKET_W-1:0] rem_bucket;

    logic [AW-1:0]      addr;
    logic [WORD_W-1:0]  mem [DEPTH];
    logic [WORD_W-1:0]  mem_q_reg;

    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_DATA_W-1:0] m_tdata_next;
    logic [BUCKET_W-1:0] bucket_out;
    logic [WORD_W-1:0]  rdata_out;

    always_ff @(posedge aclk) begin
        if (cmd.take && s_tvalid) begin
            cmd_reg   <= cmd_t'(s_tdata[CMD_LSB +: 3]);
            id_reg    <= s_tdata[ID_LSB +: ID_W];
            off_reg   <= s_tdata[OFF_LSB +: OFF_W];
            wdata_reg <= s_tdata[WDATA_LSB +: WORD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.compare) begin
            for (int i = 0; i < PAGES; i++) begin
                match_reg[i] <= in_use_reg[i] && (owner_reg[i] == id_reg);
            end
            free_reg <= ~in_use_reg;
        end
    end

    always_comb begin
        found_next     = 1'b0;
        full_next      = 1'b1;
        page_next      = '0;
        free_page_next = '0;
        for (int i = PAGES - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                found_next = 1'b1;
                page_next  = PW'(i);
            end
            if (free_reg[i]) begin
                full_next      = 1'b0;
                free_page_next = PW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.encode) begin
            found_reg     <= found_next;
            full_reg      <= full_next;
            page_reg      <= page_next;
            free_page_reg <= free_page_next;
        end
    end

    assign off_ok = 32'(off_reg) < 32'(PAGE_WORDS);
    assign addr   = AW'(page_reg) * AW'(PAGE_WORDS) + AW'(off_reg);

    always_comb begin
        alloc_en  = 1'b0;
        del_en    = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rem_start = 1'b0;
        ok_next   = 1'b0;
        if (cmd.execute) begin
            unique case (cmd_reg)
                CMD_ALLOC: begin
                    alloc_en = !found_reg && !full_reg;
                    ok_next  = alloc_en;
                end
                CMD_SEARCH: begin
                    rem_start = found_reg;
                    ok_next   = found_reg;
                end
                CMD_WRITE: begin
                    wr_en   = found_reg && off_ok;
                    ok_next = wr_en;
                end
                CMD_READ: begin
                    rd_en   = found_reg && off_ok;
                    ok_next = rd_en;
                end
                CMD_DELETE: begin
                    del_en  = found_reg;
                    ok_next = found_reg;
                end
                default: ok_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else if (alloc_en) begin
            in_use_reg[free_page_reg] <= 1'b1;
        end else if (del_en) begin
            in_use_reg[page_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (alloc_en) begin
            owner_reg[free_page_reg] <= id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            ok_reg     <= ok_next;
            rd_sel_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata_reg;
        end
        if (rd_en) begin
            mem_q_reg <= mem[addr];
        end
    end

    ppmt_rem #(
        .DIVISOR (PAGES)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (id_reg),
        .busy     (rem_busy),
        .bucket   (rem_bucket)
    );

    assign bucket_out = (ok_reg && cmd_reg == CMD_SEARCH) ? rem_bucket : '0;
    assign rdata_out  = rd_sel_reg ? mem_q_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_comb begin
        m_tdata_next                        = '0;
        m_tdata_next[OK_LSB]                = ok_reg;
        m_tdata_next[BUCKET_LSB +: BUCKET_W] = bucket_out;
        m_tdata_next[RDATA_LSB +: WORD_W]    = rdata_out;
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.rem_busy = rem_busy;
    assign stat.out_free = !m_tvalid_reg || m_tready;

endmodule

### design/paged_process_memory_table_top.sv
// Paged process memory table: one page of PAGE_WORDS words per process ID.
// Input stream s_*: one request per transfer (allocate, search, write word,
// read word, delete). Output stream m_*: exactly one response per request,
// in request order.
// The response is loaded after this sequence: owner compare, page encode,
// page-table/word-memory access, response load. A new request is taken only
// once the response of the last one has been loaded. A search with PAGES not
// a power of two holds the response load until the reciprocal-multiply
// bucket remainder is ready.
// Reset (aresetn low, synchronous) frees every page and drops any pending
// response; word memory contents are kept and never cleared.
// When m_tready is low the response holds in the output register; the next
// request is still taken and worked on, and waits in its last step until the
// output register frees.
module paged_process_memory_table_top #(
    parameter int PAGES      = ppmt_pkg::PAGES_DEF,
    parameter int PAGE_WORDS = ppmt_pkg::PAGE_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] cmd, [34:3] process_id, [41:35] word_offset, [73:42] write_data
    input  logic [ppmt_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] ok, [4:1] bucket_index, [36:5] read_data
    output logic [ppmt_pkg::M_DATA_W-1:0] m_tdata
);
    import ppmt_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    ppmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppmt_dp #(
        .PAGES      (PAGES),
        .PAGE_WORDS (PAGE_WORDS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = cmd.take;

endmodule

### sim/paged_process_memory_table_top_tb.sv
`timescale 1ns / 1ps

import ppmt_pkg::*;

typedef struct packed {
    logic [2:0]         cmd;
    logic [ID_W-1:0]    process_id;
    logic [OFF_W-1:0]   word_offset;
    logic signed [WORD_W-1:0] write_data;
} request_t;

typedef struct packed {
    logic                     ok;
    logic [BUCKET_W-1:0]      bucket_index;
    logic signed [WORD_W-1:0] read_data;
} response_t;

class page_table_scoreboard;
    localparam int NPAGES = PAGES_DEF;
    localparam int NWORDS = PAGE_WORDS_DEF;

    bit              in_use [NPAGES];
    logic [ID_W-1:0] owner [NPAGES];
    logic [WORD_W-1:0] words [NPAGES*NWORDS];
    bit              written [NPAGES*NWORDS];
    int              live;
    response_t       expected_responses[$];
    int              requests;
    int              responses;
    int              successes;
    int              full_refusals;

    function new();
        foreach (in_use[p]) in_use[p] = 1'b0;
        foreach (written[w]) written[w] = 1'b0;
        live = 0;
        requests = 0;
        responses = 0;
        successes = 0;
        full_refusals = 0;
    endfunction

    function int find_page(logic [ID_W-1:0] id);
        for (int p = 0; p < NPAGES; p++) begin
            if (in_use[p] && owner[p] == id) return p;
        end
        return -1;
    endfunction

    function void note_request(request_t r);
        response_t rsp;
        int        page;
        int        idx;
        page = find_page(r.process_id);
        idx  = page * NWORDS + int'(r.word_offset);
        rsp  = '0;
        case (cmd_t'(r.cmd))
            CMD_ALLOC: begin
                if (page < 0) begin
                    for (int p = 0; p < NPAGES; p++) begin
                        if (!in_use[p]) begin
                            in_use[p] = 1'b1;
                            owner[p]  = r.process_id;
                            live++;
                            rsp.ok = 1'b1;
                            break;
                        end
                    end
                    if (!rsp.ok) full_refusals++;
                end
            end
            CMD_SEARCH: begin
                if (page >= 0) begin
                    rsp.ok = 1'b1;
                    rsp.bucket_index = BUCKET_W'(r.process_id % NPAGES);
                end
            end
            CMD_WRITE: begin
                if (page >= 0 && r.word_offset < NWORDS) begin
                    words[idx]   = r.write_data;
                    written[idx] = 1'b1;
                    rsp.ok = 1'b1;
                end
            end
            CMD_READ: begin
                if (page >= 0 && r.word_offset < NWORDS) begin
                    rsp.read_data = words[idx];
                    rsp.ok = 1'b1;
                end
            end
            CMD_DELETE: begin
                if (page >= 0) begin
                    in_use[page] = 1'b0;
                    if (live > 0) live--;
                    rsp.ok = 1'b1;
                end
            end
            default: ;
        endcase
        requests++;
        if (rsp.ok) successes++;
        expected_responses.push_back(rsp);
    endfunction

    // returns an empty string when the response matches
    function string check_response(logic [M_DATA_W-1:0] tdata);
        response_t want;
        response_t got;
        string     msg;
        msg = "";
        got.ok           = tdata[OK_LSB];
        got.bucket_index = tdata[BUCKET_LSB +: BUCKET_W];
        got.read_data    = tdata[RDATA_LSB +: WORD_W];
        if (expected_responses.size() == 0) begin
            return $sformatf("response %h with no request outstanding", tdata);
        end
        want = expected_responses.pop_front();
        responses++;
        if (got.ok !== want.ok)
            msg = {msg, $sformatf(" ok %b exp %b", got.ok, want.ok)};
        if (got.bucket_index !== want.bucket_index)
            msg = {msg, $sformatf(" bucket %0d exp %0d", got.bucket_index,
                                  want.bucket_index)};
        if (got.read_data !== want.read_data)
            msg = {msg, $sformatf(" read_data %h exp %h", got.read_data, want.read_data)};
        if (msg != "") msg = $sformatf("response %0d:%s", responses, msg);
        return msg;
    endfunction

    function int pending();
        return expected_responses.size();
    endfunction
endclass

module paged_process_memory_table_top_tb;

    localparam int NPAGES      = PAGES_DEF;
    localparam int NWORDS      = PAGE_WORDS_DEF;
    localparam int RANDOM_REQS = 1200;
    localparam int PHASE_LEN   = 100;
    localparam int POOL_SIZE   = 24;
    localparam int CYCLE_LIMIT = 1000000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    page_table_scoreboard sb = new();
    int                   mismatches  = 0;
    int                   cycle_count = 0;
    bit                   quiet       = 1'b0;
    logic [ID_W-1:0]      id_pool [POOL_SIZE];
    string                mon_msg;

    paged_process_memory_table_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic request_t make_req(logic [2:0] cmd, logic [ID_W-1:0] id,
                                          logic [OFF_W-1:0] off, logic [WORD_W-1:0] data);
        request_t r;
        r.cmd         = cmd;
        r.process_id  = id;
        r.word_offset = off;
        r.write_data  = data;
        return r;
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_request(request_t r);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[CMD_LSB +: 3]       = r.cmd;
        d[ID_LSB +: ID_W]     = r.process_id;
        d[OFF_LSB +: OFF_W]   = r.word_offset;
        d[WDATA_LSB +: WORD_W] = r.write_data;
        return d;
    endfunction

    function automatic request_t random_request(bit fill_phase);
        request_t r;
        int       w;
        int       page;
        int       start;
        bit       found;
        r.process_id = ($urandom_range(99) < 10) ? ID_W'($urandom)
                                                 : id_pool[$urandom_range(POOL_SIZE-1)];
        r.word_offset = ($urandom_range(99) < 85) ? OFF_W'($urandom_range(NWORDS-1))
                                                  : OFF_W'($urandom_range(127, NWORDS));
        r.write_data = $urandom;
        w = $urandom_range(99);
        if (fill_phase) begin
            if      (w < 40) r.cmd = CMD_ALLOC;
            else if (w < 52) r.cmd = CMD_SEARCH;
            else if (w < 75) r.cmd = CMD_WRITE;
            else if (w < 95) r.cmd = CMD_READ;
            else if (w < 98) r.cmd = CMD_DELETE;
            else             r.cmd = 3'($urandom_range(7, 5));
        end else begin
            if      (w < 10) r.cmd = CMD_ALLOC;
            else if (w < 25) r.cmd = CMD_SEARCH;
            else if (w < 48) r.cmd = CMD_WRITE;
            else if (w < 72) r.cmd = CMD_READ;
            else if (w < 97) r.cmd = CMD_DELETE;
            else             r.cmd = 3'($urandom_range(7, 5));
        end
        // never read a word that has not been written
        page = sb.find_page(r.process_id);
        if (r.cmd == CMD_READ && page >= 0 && r.word_offset < NWORDS &&
                !sb.written[page*NWORDS + int'(r.word_offset)]) begin
            found = 1'b0;
            start = $urandom_range(NWORDS-1);
            for (int k = 0; k < NWORDS; k++) begin
                if (!found && sb.written[page*NWORDS + (start + k) % NWORDS]) begin
                    r.word_offset = OFF_W'((start + k) % NWORDS);
                    found = 1'b1;
                end
            end
            if (!found) r.cmd = CMD_WRITE;
        end
        return r;
    endfunction

    task automatic send_request(request_t r);
        int gap;
        s_tdata  <= pack_request(r);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(r);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        int run;
        int stall;
        @(posedge aclk);
        forever begin
            run = $urandom_range(8, 1);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_msg = sb.check_response(m_tdata);
            if (mon_msg != "") report_mismatch(mon_msg);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, sb.pending());
        $display("paged_process_memory_table_top_tb: FAIL");
        $finish;
    end

    initial begin
        request_t directed[$];
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;

        directed.push_back(make_req(CMD_SEARCH, 32'h0, 7'd0, 32'h0));
        directed.push_back(make_req(CMD_WRITE,  32'h0, 7'd0, 32'h1234_5678));
        directed.push_back(make_req(CMD_READ,   32'h0, 7'd0, 32'h0));
        directed.push_back(make_req(CMD_DELETE, 32'h0, 7'd0, 32'h0));
        directed.push_back(make_req(CMD_ALLOC,  32'h0, 7'd0, 32'h0));
        directed.push_back(make_req(CMD_ALLOC,  32'hFFFF_FFFF, 7'd127, 32'hFFFF_FFFF));
        directed.push_back(make_req(CMD_ALLOC,  32'h0, 7'd0, 32'h0));
        directed.push_back(make_req(CMD_WRITE,  32'h0, 7'd0, 32'h8000_0000));
        directed.push_back(make_req(CMD_WRITE,  32'hFFFF_FFFF, 7'(NWORDS-1), 32'h7FFF_FFFF));
        directed.push_back(make_req(CMD_WRITE,  32'h0, 7'(NWORDS), 32'hFFFF_FFFF));
        directed.push_back(make_req(CMD_READ,   32'hFFFF_FFFF, 7'd127, 32'h0));
        directed.push_back(make_req(CMD_READ,   32'h0, 7'd0, 32'h0));
        directed.push_back(make_req(CMD_READ,   32'hFFFF_FFFF, 7'(NWORDS-1), 32'h0));
        directed.push_back(make_req(CMD_SEARCH, 32'h0, 7'd0, 32'h0));
        directed.push_back(make_req(CMD_SEARCH, 32'hFFFF_FFFF, 7'd0, 32'h0));
        directed.push_back(make_req(3'd5, 32'h0, 7'd0, 32'h0));
        directed.push_back(make_req(3'd6, 32'hFFFF_FFFF, 7'd127, 32'hFFFF_FFFF));
        directed.push_back(make_req(3'd7, 32'h0, 7'd0, 32'h0));
        directed.push_back(make_req(CMD_DELETE, 32'h0, 7'd0, 32'h0));
        directed.push_back(make_req(CMD_SEARCH, 32'h0, 7'd0, 32'h0));
        // page 0 reused: its old word must survive the free
        directed.push_back(make_req(CMD_ALLOC,  32'h5A5A_5A5A, 7'd0, 32'h0));
        directed.push_back(make_req(CMD_READ,   32'h5A5A_5A5A, 7'd0, 32'h0));
        directed.push_back(make_req(CMD_DELETE, 32'hFFFF_FFFF, 7'd0, 32'h0));
        directed.push_back(make_req(CMD_DELETE, 32'h5A5A_5A5A, 7'd0, 32'h0));
        foreach (directed[i]) send_request(directed[i]);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            quiet = ((i / PHASE_LEN) % 4 == 3);
            send_request(random_request((i / PHASE_LEN) % 2 == 0));
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d requests, %0d responses checked, %0d succeeded",
                 sb.requests, sb.responses, sb.successes);
        $display("allocations refused on a full table: %0d, mismatches: %0d",
                 sb.full_refusals, mismatches);
        if (mismatches == 0) begin
            $display("paged_process_memory_table_top_tb: PASS");
        end else begin
            $display("paged_process_memory_table_top_tb: FAIL");
        end
        $finish;
    end

endmodule
